[sv/wfsc_pkg.sv]
`timescale 1ns / 1ps
package wfsc_pkg;

	localparam int SENSOR_BITS_DEF = 12;
	localparam int CFG_W = 12;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_FOLLOW_RIGHT = 3'd0;
	localparam logic [CFG_IW-1:0] REG_WALL_LOW     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_WALL_HIGH    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_FRONT_TH     = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SIDE_TH      = 3'd4;

	localparam logic [1:0] CMD_DRIVE  = 2'd0;
	localparam logic [1:0] CMD_BACKUP = 2'd1;
	localparam logic [1:0] CMD_TURN   = 2'd2;

	localparam int STEP_LIMIT = 12500;

	typedef struct packed {
		logic load;
		logic start1;
		logic apply1;
		logic start2;
		logic apply2;
		logic start3;
		logic finish;
		logic pop;
	} wfsc_cmd_t;

	typedef struct packed {
		logic busy;
		logic last;
	} wfsc_sts_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [8:0]  backup;
		logic [10:0] turn;
		logic [5:0]  lspd;
		logic [5:0]  rspd;
		logic        last;
	} wfsc_res_t;

endpackage

[sv/wall_follow_speed_control.sv]
`timescale 1ns / 1ps
// an item is taken in idle, then passes three start and wait steps: the bump handling, the error
// ratio by one serial division pass of SENSOR_BITS+7 bits with the lost-wall check, and the speeds
// then its results (1 to 3) are emitted; no new item is taken until the last result is out
// the next item can be taken at the earliest the cycle after the last result of the previous one
// reset: asynchronous, active low; restores register defaults, target 400, zero previous error and history
module wall_follow_speed_control import wfsc_pkg::*; #(
	parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_IW-1:0]      cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SENSOR_BITS-1:0] wall_level,
	input  logic                   left_bump,
	input  logic                   right_bump,
	input  logic [SENSOR_BITS-1:0] front_level,
	input  logic [SENSOR_BITS-1:0] side_level,
	input  logic                   wall_near,
	input  logic [15:0]            wheel_steps,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             command,
	output logic [8:0]             backup_distance,
	output logic [10:0]            turn_angle,
	output logic [5:0]             left_speed,
	output logic [5:0]             right_speed,
	output logic                   last
);

	wfsc_cmd_t cmd;
	wfsc_sts_t sts;
	wfsc_res_t res;

	wfsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid)
	);

	wfsc_dp #(.SENSOR_BITS(SENSOR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.wall_level(wall_level), .left_bump(left_bump), .right_bump(right_bump),
		.front_level(front_level), .side_level(side_level), .wall_near(wall_near),
		.wheel_steps(wheel_steps), .res(res)
	);

	assign command         = res.command;
	assign backup_distance = res.backup;
	assign turn_angle      = res.turn;
	assign left_speed      = res.lspd;
	assign right_speed     = res.rspd;
	assign last            = res.last;

	// never take an item while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("input open during output");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("item taken but block not busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid)
		else $error("results continue after last");

endmodule

[sv/wfsc_div.sv]
`timescale 1ns / 1ps
module wfsc_div import wfsc_pkg::*; #(
	parameter int NW = 8,
	parameter int DW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);

	localparam int CNW = $clog2(NW + 1);

	logic [DW-1:0]  rem_q;
	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  dsr_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNW'(1);
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring long division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

[sv/wfsc_ctrl.sv]
`timescale 1ns / 1ps
module wfsc_ctrl import wfsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_stall,
	input  wfsc_sts_t sts,
	output wfsc_cmd_t cmd,
	output logic      in_stall,
	output logic      out_valid
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_S1   = 8'b0000_0010,
		ST_W1   = 8'b0000_0100,
		ST_S2   = 8'b0000_1000,
		ST_W2   = 8'b0001_0000,
		ST_S3   = 8'b0010_0000,
		ST_W3   = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_S1;
				end
			end
			ST_S1: begin
				cmd.start1 = 1'b1;
				state_d    = ST_W1;
			end
			ST_W1: begin
				if (!sts.busy) begin
					cmd.apply1 = 1'b1;
					state_d    = ST_S2;
				end
			end
			ST_S2: begin
				cmd.start2 = 1'b1;
				state_d    = ST_W2;
			end
			ST_W2: begin
				if (!sts.busy) begin
					cmd.apply2 = 1'b1;
					state_d    = ST_S3;
				end
			end
			ST_S3: begin
				cmd.start3 = 1'b1;
				state_d    = ST_W3;
			end
			ST_W3: begin
				if (!sts.busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_stall) begin
					cmd.pop = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = state_q == ST_EMIT;

endmodule

[sv/wfsc_dp.sv]
`timescale 1ns / 1ps
module wfsc_dp import wfsc_pkg::*; #(
	parameter int SENSOR_BITS = SENSOR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wfsc_cmd_t              cmd,
	output wfsc_sts_t              sts,
	input  logic                   cfg_write,
	input  logic [CFG_IW-1:0]      cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic [SENSOR_BITS-1:0] wall_level,
	input  logic                   left_bump,
	input  logic                   right_bump,
	input  logic [SENSOR_BITS-1:0] front_level,
	input  logic [SENSOR_BITS-1:0] side_level,
	input  logic                   wall_near,
	input  logic [15:0]            wheel_steps,
	output wfsc_res_t              res
);

	localparam int SB = SENSOR_BITS;
	localparam int QW = SB + 7;
	localparam int TW = (SB > 13) ? SB : 13;
	localparam int MW = 22;
	localparam int CW = SB + 2;
	localparam int SW = 26;

	// reciprocals ceil(2^27 / c), exact for operands below 2^22
	localparam logic [25:0] RCP_3  = 26'd44739243;
	localparam logic [25:0] RCP_5  = 26'd26843546;
	localparam logic [25:0] RCP_10 = 26'd13421773;
	localparam logic [25:0] RCP_12 = 26'd11184811;
	localparam logic [25:0] RCP_18 = 26'd7456541;
	localparam logic [25:0] RCP_22 = 26'd6100806;
	localparam logic [25:0] RCP_25 = 26'd5368710;

	function automatic logic [MW-1:0] cdiv(input logic [MW-1:0] x, input logic [25:0] m);
		logic [47:0] prod;
		prod = 48'(x) * 48'(m);
		return {1'b0, prod[47:27]};
	endfunction

	// configuration
	logic             right_q;
	logic [CFG_W-1:0] low_q, high_q, fth_q, sth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= 1'b0;
			low_q   <= 12'd200;
			high_q  <= 12'd800;
			fth_q   <= 12'd1000;
			sth_q   <= 12'd1000;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FOLLOW_RIGHT: right_q <= cfg_data[0];
				REG_WALL_LOW:     low_q   <= cfg_data;
				REG_WALL_HIGH:    high_q  <= cfg_data;
				REG_FRONT_TH:     fth_q   <= cfg_data;
				REG_SIDE_TH:      sth_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched item
	logic [SB-1:0] wall_q, front_q, side_q;
	logic          lb_q, rb_q, near_q;
	logic [15:0]   steps_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wall_q  <= wall_level;
			lb_q    <= left_bump;
			rb_q    <= right_bump;
			front_q <= front_level;
			side_q  <= side_level;
			near_q  <= wall_near;
			steps_q <= wheel_steps;
		end
	end

	logic nearb, farb;
	assign nearb = right_q ? rb_q : lb_q;
	assign farb  = right_q ? lb_q : rb_q;

	// state
	logic [11:0]        target_q;
	logic signed [20:0] prev_q;
	logic [SB-1:0]      hist_q [0:2];
	logic signed [20:0] p_q;
	logic signed [21:0] d_q;
	logic               hi;

	assign hi = target_q > 12'd300;

	// serial divider for the error ratio, constant divisions by reciprocal
	logic [QW-1:0] a_dvd, qa;
	logic [11:0]   a_dsr;
	logic [MW-1:0] p_mag, d_mag;
	logic [MW-1:0] lim_q, qb_q, qc_q, qd_q;
	logic [SB-1:0] w3_q;
	logic          a_busy;

	assign p_mag = p_q[20] ? MW'(-{p_q[20], p_q}) : MW'({1'b0, p_q});
	assign d_mag = d_q[21] ? MW'(-d_q) : MW'(d_q);

	assign a_dvd = QW'(wall_q) * QW'(100);
	assign a_dsr = (target_q == 12'd0) ? 12'd1 : target_q;

	wfsc_div #(.NW(QW), .DW(12)) u_div_a (
		.clk(clk), .arst_n(arst_n), .start(cmd.start2),
		.dividend(a_dvd), .divisor(a_dsr), .busy(a_busy), .quotient(qa)
	);

	always_ff @(posedge clk) begin
		if (cmd.start1) w3_q <= SB'(cdiv(MW'(wall_q), RCP_3));
		if (cmd.start2) lim_q <= cdiv(MW'(target_q), RCP_25);
		if (cmd.start3) begin
			qb_q <= cdiv(p_mag, hi ? RCP_12 : RCP_22);
			qc_q <= cdiv(d_mag, hi ? RCP_5 : RCP_10);
			qd_q <= cdiv(p_mag, hi ? RCP_10 : RCP_18);
		end
	end

	// bump target update
	logic [TW-1:0] tsel, tlo, tcl;
	always_comb begin
		tsel = (TW'(wall_q) > TW'(low_q)) ? TW'(w3_q) : TW'(target_q) + TW'(200);
		tlo  = (tsel < TW'(low_q)) ? TW'(low_q) : tsel;
		tcl  = (tlo > TW'(high_q)) ? TW'(high_q) : tlo;
	end

	// lost wall and error terms
	logic                 hist_on, lost;
	logic signed [CW-1:0] dif1, dif2, lim;
	logic signed [31:0]   pw;
	logic signed [20:0]   p_sat;
	always_comb begin
		hist_on = target_q >= 12'd200;
		lim     = $signed({1'b0, lim_q[CW-2:0]});
		dif1    = $signed(CW'(hist_q[0])) - $signed(CW'(wall_q));
		dif2    = $signed(CW'(hist_q[1])) - $signed(CW'(hist_q[0]));
		lost    = (wall_q < SB'(100)) && (dif1 > lim) && (dif2 > lim);
		pw      = $signed({{(32-QW){1'b0}}, qa}) - 32'sd100;
		if (pw > 32'sd1048575) begin
			p_sat = 21'sd1048575;
		end else if (pw < -32'sd1048576) begin
			p_sat = -21'sd1048576;
		end else begin
			p_sat = pw[20:0];
		end
	end

	// wheel speeds
	logic signed [SW-1:0] vp1, vp2, vd, fs, os;
	logic [5:0]           fs6, os6;
	logic [10:0]          ang;
	logic                 front_clr;
	always_comb begin
		vp1 = p_q[20] ? -$signed(SW'(qb_q)) : $signed(SW'(qb_q));
		vp2 = p_q[20] ? -$signed(SW'(qd_q)) : $signed(SW'(qd_q));
		vd  = d_q[21] ? -$signed(SW'(qc_q)) : $signed(SW'(qc_q));
		if (hi) begin
			fs = SW'(25) + vp1 + vd;
			os = SW'(25) - vp2 - vd;
			if (os > SW'(33)) begin
				fs = SW'(5);
				os = SW'(33);
			end
		end else begin
			fs = SW'(15) + vp1 + vd;
			os = SW'(15) - vp2 - vd;
			if (os > SW'(18)) begin
				fs = SW'(5);
				os = SW'(18);
			end
			if (fs > SW'(20)) fs = SW'(20);
			if (fs < SW'(4)) fs = SW'(4);
			if (os < SW'(4)) os = SW'(4);
			if (fs - os > SW'(5)) fs = os + SW'(5);
		end
		// halve toward zero
		if (near_q) begin
			fs = (fs + (fs[SW-1] ? SW'(1) : SW'(0))) >>> 1;
			os = (os + (os[SW-1] ? SW'(1) : SW'(0))) >>> 1;
		end
		if (fs < SW'(0)) fs = SW'(0);
		if (fs > SW'(40)) fs = SW'(40);
		if (os < SW'(0)) os = SW'(0);
		fs6 = fs[5:0];
		os6 = os[5:0];
		front_clr = TW'(front_q) < TW'(fth_q);
		if (steps_q < 16'(STEP_LIMIT)) begin
			ang = (TW'(front_q) > TW'(fth_q)) ? 11'd800 : 11'd400;
		end else begin
			ang = 11'd900;
		end
	end

	// result slots
	wfsc_res_t res_q [0:2];
	logic [1:0] wr_q, idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 12'd400;
			prev_q   <= '0;
			for (int i = 0; i < 3; i++) hist_q[i] <= '0;
			wr_q     <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.load) begin
				wr_q  <= '0;
				idx_q <= '0;
			end
			if (cmd.apply1) begin
				if (nearb) begin
					target_q <= tcl[11:0];
					for (int i = 0; i < 3; i++) hist_q[i] <= '0;
				end
				if (nearb || farb) wr_q <= wr_q + 2'd1;
			end
			if (cmd.apply2 && hist_on) begin
				hist_q[0] <= wall_q;
				hist_q[1] <= hist_q[0];
				hist_q[2] <= hist_q[1];
				if (lost) wr_q <= wr_q + 2'd1;
			end
			if (cmd.finish) begin
				wr_q <= wr_q + 2'd1;
				if (front_clr) begin
					prev_q <= p_q;
					if ((TW'(side_q) > TW'(sth_q)) && (target_q < high_q)) begin
						target_q <= target_q + 12'd1;
					end
				end else begin
					target_q <= high_q;
				end
			end
			if (cmd.pop) idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply1) begin
			if (nearb) begin
				res_q[wr_q] <= '{CMD_BACKUP, 9'd350, farb ? 11'd900 : 11'd300,
					6'd10, 6'd10, 1'b0};
			end else if (farb) begin
				res_q[wr_q] <= '{CMD_BACKUP, 9'd100, 11'd1350, 6'd15, 6'd15, 1'b0};
			end
		end
		if (cmd.apply2) begin
			p_q <= p_sat;
			d_q <= {p_sat[20], p_sat} - {prev_q[20], prev_q};
			if (hist_on && lost) begin
				res_q[wr_q] <= '{CMD_DRIVE, 9'd0, 11'd0, 6'd18, 6'd16, 1'b0};
			end
		end
		if (cmd.finish) begin
			if (front_clr) begin
				res_q[wr_q] <= '{CMD_DRIVE, 9'd0, 11'd0, right_q ? os6 : fs6,
					right_q ? fs6 : os6, 1'b1};
			end else begin
				res_q[wr_q] <= '{CMD_TURN, 9'd0, ang, 6'd15, 6'd15, 1'b1};
			end
		end
	end

	assign res      = res_q[idx_q];
	assign sts.busy = a_busy;
	assign sts.last = idx_q == (wr_q - 2'd1);

endmodule
